// ----- sv/acf_pkg.sv -----
// Shared types, constants and codes of the audio segment crossfader.
package acf_pkg;

  localparam int SAMPLE_BITS      = 24;
  localparam int TAIL_DEPTH_DEF   = 4096;
  localparam int MAX_CHANNELS_DEF = 8;
  localparam int SINE_DEPTH_DEF   = 1024;

  localparam int CC_W       = 4;
  localparam int OVL_W      = 13;
  localparam int GSTEP_W    = 16;
  localparam int GAIN_W     = 17;
  localparam int GIDX_W     = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [GAIN_W-1:0] UNITY_GAIN  = 17'd65536;
  localparam logic [GAIN_W-1:0] FADE_MAX    = 17'd131071;
  localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;

  localparam logic [CC_W-1:0]    RST_CHANNELS = 4'd2;
  localparam logic [OVL_W-1:0]   RST_OVERLAP  = 13'd255;
  localparam logic [GSTEP_W-1:0] RST_STEP     = 16'd256;

  typedef enum logic [1:0] {
    PH_A    = 2'd0,
    PH_OVL  = 2'd1,
    PH_PASS = 2'd2,
    PH_DROP = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SAT      = 2'd1,
    ST_SHORT    = 2'd2,
    ST_MISALIGN = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNELS = 4'd0,
    REG_OVERLAP  = 4'd1,
    REG_CURVE    = 4'd2,
    REG_STEP     = 4'd3
  } reg_e;

  // one classified request on its way to the mixer
  typedef struct packed {
    logic                          mix;
    logic                          use_tail;
    logic signed [SAMPLE_BITS-1:0] samp;
    logic signed [SAMPLE_BITS-1:0] tail;
    status_e                       code;
    logic                          last;
    logic                          curve;
    logic [GAIN_W-1:0]             gain;
    logic [GIDX_W-1:0]             gidx;
  } acf_entry_t;

endpackage

// ----- sv/acf_if.sv -----
// Handshake interfaces for samples in, results out and register writes.
interface acf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [acf_pkg::SAMPLE_BITS-1:0] sample_in;
  logic                                   from_second;
  logic                                   segment_end;
  modport source (output valid, sample_in, from_second, segment_end, input ready);
  modport sink (input valid, sample_in, from_second, segment_end, output ready);
endinterface

interface acf_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [acf_pkg::SAMPLE_BITS-1:0] sample_out;
  logic [1:0]                             status_code;
  logic                                   stream_last;
  modport source (output valid, sample_out, status_code, stream_last, input ready);
  modport sink (input valid, sample_out, status_code, stream_last, output ready);
endinterface

interface acf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [acf_pkg::CFG_IDX_W-1:0]     index;
  logic [acf_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/acf_front.sv -----
// Front end: registers, job sequencing, tail buffer and gain position per request.
module acf_front #(
  parameter int TAIL_DEPTH       = acf_pkg::TAIL_DEPTH_DEF,
  parameter int MAX_CHANNELS     = acf_pkg::MAX_CHANNELS_DEF,
  parameter int SINE_TABLE_DEPTH = acf_pkg::SINE_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  acf_in_if.sink                   in_s,
  acf_cfg_if.sink                  cfg_s,
  input  logic [acf_pkg::QC_W-1:0] q_count_i,
  output logic                     push_o,
  output acf_pkg::acf_entry_t      push_data_o
);

  localparam int PTR_W  = $clog2(TAIL_DEPTH);
  localparam int FILL_W = $clog2(TAIL_DEPTH + 1);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CN_W   = $clog2(MAX_CHANNELS + 1);
  localparam int PROD_W = acf_pkg::OVL_W + CN_W;
  localparam int CMP_W  = (PROD_W > FILL_W) ? PROD_W : FILL_W;
  localparam int QS_W   = acf_pkg::QC_W + 1;
  localparam int SB     = acf_pkg::SAMPLE_BITS;

  // configuration registers
  logic [acf_pkg::CC_W-1:0]    cc_q;
  logic [acf_pkg::OVL_W-1:0]   ovl_q;
  logic                        curve_q;
  logic [acf_pkg::GSTEP_W-1:0] gstep_q;
  logic [1:0]                  hold_q;

  // derived job geometry
  logic [CN_W-1:0]           ch_q;
  logic [acf_pkg::OVL_W-1:0] ov1_q;
  logic [acf_pkg::OVL_W-1:0] ovc_q;
  logic [FILL_W-1:0]         len_q;
  logic [FILL_W-1:0]         cap_tab [MAX_CHANNELS+1];
  logic [PROD_W-1:0]         ov_prod;
  logic                      ov_over;
  logic [acf_pkg::OVL_W-1:0] ovc_d;
  logic [PROD_W-1:0]         len_prod;

  // job state
  acf_pkg::phase_e           phase_q, phase_d;
  logic [FILL_W-1:0]         fill_q, fill_d;
  logic [PTR_W-1:0]          wp_q, wp_d, rp_q, rp_d, wp_inc, rp_inc;
  logic [acf_pkg::OVL_W-1:0] ofi_q, ofi_d;
  logic [CH_W-1:0]           chi_q, chi_d;
  logic [acf_pkg::GAIN_W-1:0] fade_q, fade_d;

  logic signed [SB-1:0] tail_mem [TAIL_DEPTH];
  logic signed [SB-1:0] rd_q;
  logic                 mem_we;

  logic                       accept, fe, have, ovl_done, job_rst, drop_after;
  logic [CN_W:0]              chi_ext;
  logic [acf_pkg::OVL_W:0]    ofi_ext;
  logic [acf_pkg::GAIN_W:0]   fade_sum;
  logic [acf_pkg::GAIN_W-1:0] gain_p;
  logic [30:0]                gprod;
  logic [14:0]                graw;
  logic [acf_pkg::GIDX_W-1:0] gidx;
  acf_pkg::status_e           code_v;
  acf_pkg::acf_entry_t        ent_d, ent_q;
  logic                       ent_v_d, ent_v_q;

  // register port
  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q    <= acf_pkg::RST_CHANNELS;
      ovl_q   <= acf_pkg::RST_OVERLAP;
      curve_q <= 1'b0;
      gstep_q <= acf_pkg::RST_STEP;
      hold_q  <= 2'd2;
    end else if (cfg_s.valid) begin
      hold_q <= 2'd2;
      case (acf_pkg::reg_e'(cfg_s.index))
        acf_pkg::REG_CHANNELS: cc_q    <= cfg_s.data[acf_pkg::CC_W-1:0];
        acf_pkg::REG_OVERLAP:  ovl_q   <= cfg_s.data[acf_pkg::OVL_W-1:0];
        acf_pkg::REG_CURVE:    curve_q <= cfg_s.data[0];
        acf_pkg::REG_STEP:     gstep_q <= cfg_s.data;
        default: ;
      endcase
    end else if (hold_q != 2'd0) begin
      hold_q <= hold_q - 2'd1;
    end
  end

  // per-channel-count capacity of the tail in frames
  assign cap_tab[0] = FILL_W'(TAIL_DEPTH);
  for (genvar g = 1; g <= MAX_CHANNELS; g++) begin : g_cap
    localparam int CAPV = TAIL_DEPTH / g;
    assign cap_tab[g] = FILL_W'(CAPV);
  end

  assign ov_prod  = PROD_W'(ov1_q) * PROD_W'(ch_q);
  assign ov_over  = CMP_W'(ov_prod) > CMP_W'(TAIL_DEPTH);
  assign ovc_d    = ov_over ? acf_pkg::OVL_W'(cap_tab[ch_q]) : ov1_q;
  assign len_prod = PROD_W'(ovc_d) * PROD_W'(ch_q);

  // geometry settles through ch_q and ov1_q, then ovc_q and len_q; input is held off meanwhile
  always_ff @(posedge clk_i) begin
    if (cc_q == '0) begin
      ch_q <= CN_W'(1);
    end else if (32'(cc_q) > MAX_CHANNELS) begin
      ch_q <= CN_W'(MAX_CHANNELS);
    end else begin
      ch_q <= CN_W'(cc_q);
    end
    ov1_q <= (ovl_q == '0) ? acf_pkg::OVL_W'(1) : ovl_q;
    ovc_q <= ovc_d;
    len_q <= FILL_W'(len_prod);
  end

  assign in_s.ready = (hold_q == 2'd0) &&
                      (QS_W'(q_count_i) + QS_W'(ent_v_q) < QS_W'(acf_pkg::QUEUE_DEPTH));
  assign accept     = in_s.valid && in_s.ready;

  assign chi_ext  = (CN_W+1)'(chi_q) + (CN_W+1)'(1);
  assign fe       = chi_ext >= (CN_W+1)'(ch_q);
  assign ofi_ext  = (acf_pkg::OVL_W+1)'(ofi_q) + (acf_pkg::OVL_W+1)'(1);
  assign ovl_done = fe && (ofi_ext >= (acf_pkg::OVL_W+1)'(ovc_q));
  assign wp_inc   = (wp_q == PTR_W'(TAIL_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
  assign rp_inc   = (rp_q == PTR_W'(TAIL_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
  assign fade_sum = (acf_pkg::GAIN_W+1)'(fade_q) + (acf_pkg::GAIN_W+1)'(gstep_q);

  // gain position and its quarter-sine index
  assign gain_p = (fade_q > acf_pkg::UNITY_GAIN) ? acf_pkg::UNITY_GAIN : fade_q;
  assign gprod  = 31'(gain_p) * 31'(SINE_TABLE_DEPTH) + 31'd32768;
  assign graw   = gprod[30:16];
  assign gidx   = (32'(graw) > SINE_TABLE_DEPTH) ? acf_pkg::GIDX_W'(SINE_TABLE_DEPTH)
                                                 : acf_pkg::GIDX_W'(graw);

  always_comb begin
    phase_d    = phase_q;
    fill_d     = fill_q;
    wp_d       = wp_q;
    rp_d       = rp_q;
    ofi_d      = ofi_q;
    chi_d      = chi_q;
    fade_d     = fade_q;
    mem_we     = 1'b0;
    have       = 1'b0;
    job_rst    = 1'b0;
    drop_after = 1'b0;
    code_v     = acf_pkg::ST_OK;
    ent_v_d    = 1'b0;
    ent_d.mix      = 1'b0;
    ent_d.use_tail = 1'b0;
    ent_d.samp     = in_s.sample_in;
    ent_d.tail     = '0;
    ent_d.code     = acf_pkg::ST_OK;
    ent_d.last     = 1'b0;
    ent_d.curve    = curve_q;
    ent_d.gain     = gain_p;
    ent_d.gidx     = gidx;
    if (accept) begin
      case (phase_q)
        acf_pkg::PH_A: begin
          if (!in_s.from_second) begin
            have = fill_q >= len_q;
            if (have) begin
              rp_d = rp_inc;
            end else begin
              fill_d = fill_q + FILL_W'(1);
            end
            mem_we         = 1'b1;
            wp_d           = wp_inc;
            chi_d          = fe ? '0 : chi_q + CH_W'(1);
            ent_d.samp     = '0;
            ent_d.use_tail = have;
            ent_v_d        = have;
            if (in_s.segment_end) begin
              if (!fe) begin
                code_v = acf_pkg::ST_MISALIGN;
              end else if (fill_d < len_q) begin
                code_v = acf_pkg::ST_SHORT;
              end
              if (code_v != acf_pkg::ST_OK) begin
                job_rst    = 1'b1;
                drop_after = 1'b1;
                ent_v_d    = 1'b1;
                ent_d.code = code_v;
                ent_d.last = 1'b1;
              end else begin
                phase_d = acf_pkg::PH_OVL;
                chi_d   = '0;
                ofi_d   = '0;
                fade_d  = acf_pkg::GAIN_W'(gstep_q);
              end
            end
          end
        end
        acf_pkg::PH_OVL: begin
          if (in_s.from_second) begin
            ent_v_d        = 1'b1;
            ent_d.mix      = 1'b1;
            ent_d.use_tail = fill_q != '0;
            if (fill_q != '0) begin
              rp_d   = rp_inc;
              fill_d = fill_q - FILL_W'(1);
            end
            if (fe) begin
              chi_d = '0;
              if (ovl_done) begin
                phase_d = acf_pkg::PH_PASS;
                ofi_d   = '0;
              end else begin
                ofi_d  = ofi_q + acf_pkg::OVL_W'(1);
                fade_d = (fade_sum > (acf_pkg::GAIN_W+1)'(acf_pkg::FADE_MAX)) ?
                         acf_pkg::FADE_MAX : fade_sum[acf_pkg::GAIN_W-1:0];
              end
            end else begin
              chi_d = chi_q + CH_W'(1);
            end
            if (in_s.segment_end) begin
              job_rst    = 1'b1;
              ent_d.last = 1'b1;
              if (!fe) begin
                ent_d.code = acf_pkg::ST_MISALIGN;
              end else if (!ovl_done) begin
                ent_d.code = acf_pkg::ST_SHORT;
              end
            end
          end
        end
        acf_pkg::PH_PASS: begin
          if (in_s.from_second) begin
            ent_v_d = 1'b1;
            chi_d   = fe ? '0 : chi_q + CH_W'(1);
            if (in_s.segment_end) begin
              job_rst    = 1'b1;
              ent_d.last = 1'b1;
              ent_d.code = fe ? acf_pkg::ST_OK : acf_pkg::ST_MISALIGN;
            end
          end
        end
        acf_pkg::PH_DROP: begin
          // discard the rest of a rejected second segment
          if (in_s.from_second && in_s.segment_end) begin
            job_rst = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (job_rst) begin
      fill_d  = '0;
      wp_d    = '0;
      rp_d    = '0;
      ofi_d   = '0;
      chi_d   = '0;
      fade_d  = acf_pkg::GAIN_W'(gstep_q);
      phase_d = drop_after ? acf_pkg::PH_DROP : acf_pkg::PH_A;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= acf_pkg::PH_A;
      fill_q  <= '0;
      wp_q    <= '0;
      rp_q    <= '0;
      ofi_q   <= '0;
      chi_q   <= '0;
      fade_q  <= acf_pkg::GAIN_W'(acf_pkg::RST_STEP);
      ent_v_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      ofi_q   <= ofi_d;
      chi_q   <= chi_d;
      fade_q  <= fade_d;
      ent_v_q <= ent_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  // tail buffer: one write and one registered read per cycle, read sees old data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tail_mem[wp_q] <= in_s.sample_in;
    end
    rd_q <= tail_mem[rp_q];
  end

  always_comb begin
    push_data_o      = ent_q;
    push_data_o.tail = ent_q.use_tail ? rd_q : '0;
  end
  assign push_o = ent_v_q;

endmodule

// ----- sv/acf_queue.sv -----
// Short request queue between the front end and the mixer.
module acf_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  acf_pkg::acf_entry_t      push_data_i,
  input  logic                     pop_i,
  output logic                     valid_o,
  output acf_pkg::acf_entry_t      head_o,
  output logic [acf_pkg::QC_W-1:0] count_o
);

  localparam int QP_W = $clog2(acf_pkg::QUEUE_DEPTH);

  acf_pkg::acf_entry_t       slot_q [acf_pkg::QUEUE_DEPTH];
  logic [QP_W-1:0]           wr_q, rd_q;
  logic [acf_pkg::QC_W-1:0]  cnt_q;
  logic                      do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = cnt_q != '0;
  assign head_o  = slot_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QP_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QP_W'(1);
      end
      case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + acf_pkg::QC_W'(1);
        2'b01:   cnt_q <= cnt_q - acf_pkg::QC_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/acf_back.sv -----
// Back end: gain lookup, two multipliers, rounding and saturation, result register.
module acf_back #(
  parameter int SINE_TABLE_DEPTH = acf_pkg::SINE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  acf_pkg::acf_entry_t q_head_i,
  output logic                pop_o,
  acf_out_if.source           out_s
);

  localparam int SI_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SB   = acf_pkg::SAMPLE_BITS;
  localparam int GW   = acf_pkg::GAIN_W;
  localparam int PW   = GW + 1 + SB;
  localparam int RW   = PW + 1 - 16;

  typedef logic [GW-1:0] rom_t [SINE_TABLE_DEPTH+1];

  // quarter sine in Q16 by an eight-term integer series
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] theta, x2, term, sum, r;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      theta = 64'(k) * acf_pkg::HALF_PI_Q30 / SINE_TABLE_DEPTH;
      x2    = (theta * theta) >> 30;
      sum   = theta;
      term  = ((theta * x2) >> 30) / 6;
      sum   = (sum >= term) ? sum - term : 64'd0;
      term  = ((term * x2) >> 30) / 20;
      sum   = sum + term;
      term  = ((term * x2) >> 30) / 42;
      sum   = (sum >= term) ? sum - term : 64'd0;
      term  = ((term * x2) >> 30) / 72;
      sum   = sum + term;
      term  = ((term * x2) >> 30) / 110;
      sum   = (sum >= term) ? sum - term : 64'd0;
      term  = ((term * x2) >> 30) / 156;
      sum   = sum + term;
      term  = ((term * x2) >> 30) / 210;
      sum   = (sum >= term) ? sum - term : 64'd0;
      r     = (sum + 64'd8192) >> 14;
      rom[k] = (r > 64'd65536) ? acf_pkg::UNITY_GAIN : r[GW-1:0];
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic                 en;
  logic [SI_W-1:0]      gi, gc;

  // stage 1: gains and operands
  logic                 v1_q, mix1_q, last1_q;
  logic [GW-1:0]        ga1_q, gb1_q;
  logic signed [SB-1:0] a1_q, b1_q;
  acf_pkg::status_e     code1_q;

  // stage 2: products
  logic                 v2_q, mix2_q, last2_q;
  logic signed [PW-1:0] pa2_q, pb2_q;
  logic signed [SB-1:0] b2_q;
  acf_pkg::status_e     code2_q;

  // stage 3: result
  logic signed [PW:0]   sum3;
  logic signed [RW-1:0] r3;
  logic                 sat3;
  logic signed [SB-1:0] mix3;
  logic                 out_v_q, out_last_q;
  logic signed [SB-1:0] out_samp_q;
  acf_pkg::status_e     out_code_q;

  assign en    = !out_v_q || out_s.ready;
  assign pop_o = en && q_valid_i;

  assign gi = q_head_i.gidx[SI_W-1:0];
  assign gc = SI_W'(SINE_TABLE_DEPTH) - gi;

  assign sum3 = (PW+1)'(pa2_q) + (PW+1)'(pb2_q) + (PW+1)'(32768);
  assign r3   = RW'(sum3 >>> 16);
  always_comb begin
    sat3 = 1'b0;
    mix3 = r3[SB-1:0];
    if (r3 > RW'((2 ** (SB - 1)) - 1)) begin
      sat3 = 1'b1;
      mix3 = {1'b0, {(SB-1){1'b1}}};
    end else if (r3 < -(RW'(2 ** (SB - 1)))) begin
      sat3 = 1'b1;
      mix3 = {1'b1, {(SB-1){1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= pop_o;
      v2_q    <= v1_q;
      out_v_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mix1_q  <= q_head_i.mix;
      last1_q <= q_head_i.last;
      code1_q <= q_head_i.code;
      a1_q    <= q_head_i.tail;
      // a pass-through request carries its value in the second operand
      b1_q    <= (!q_head_i.mix && q_head_i.use_tail) ? q_head_i.tail : q_head_i.samp;
      ga1_q   <= q_head_i.curve ? SINE_ROM[gc] : acf_pkg::UNITY_GAIN - q_head_i.gain;
      gb1_q   <= q_head_i.curve ? SINE_ROM[gi] : q_head_i.gain;

      mix2_q  <= mix1_q;
      last2_q <= last1_q;
      code2_q <= code1_q;
      b2_q    <= b1_q;
      pa2_q   <= $signed({1'b0, ga1_q}) * a1_q;
      pb2_q   <= $signed({1'b0, gb1_q}) * b1_q;

      out_last_q <= last2_q;
      out_samp_q <= mix2_q ? mix3 : b2_q;
      out_code_q <= (mix2_q && sat3 && (code2_q == acf_pkg::ST_OK)) ? acf_pkg::ST_SAT
                                                                    : code2_q;
    end
  end

  assign out_s.valid       = out_v_q;
  assign out_s.sample_out  = out_samp_q;
  assign out_s.status_code = out_code_q;
  assign out_s.stream_last = out_last_q;

endmodule

// ----- sv/audio_segment_crossfader_core.sv -----
// An accepted request passes the front-end entry register, the queue and the back-end stages.
// Throughput: one sample per cycle while the queue has room; the tail buffer takes one
// read and one write per cycle. Input waits after a register write while geometry settles.
// Reset clears registers, job state, queue and pipeline valids; the tail buffer is not
// cleared and its entries are read only after they were written.
module audio_segment_crossfader_core #(
  parameter int TAIL_DEPTH       = acf_pkg::TAIL_DEPTH_DEF,
  parameter int MAX_CHANNELS     = acf_pkg::MAX_CHANNELS_DEF,
  parameter int SINE_TABLE_DEPTH = acf_pkg::SINE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  acf_in_if.sink     sample_if,
  acf_out_if.source  result_if,
  acf_cfg_if.sink    cfg_if
);

  logic                     push, pop, q_valid;
  acf_pkg::acf_entry_t      push_data, q_head;
  logic [acf_pkg::QC_W-1:0] q_count;

  acf_front #(
    .TAIL_DEPTH      (TAIL_DEPTH),
    .MAX_CHANNELS    (MAX_CHANNELS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_s       (sample_if),
    .cfg_s      (cfg_if),
    .q_count_i  (q_count),
    .push_o     (push),
    .push_data_o(push_data)
  );

  acf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (q_head),
    .count_o    (q_count)
  );

  acf_back #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_head_i (q_head),
    .pop_o    (pop),
    .out_s    (result_if)
  );

endmodule

// ----- sv/acf_checker.sv -----
// Port-level checks for the crossfader core and their binding.
module acf_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [acf_pkg::SAMPLE_BITS-1:0] out_sample,
  input logic [1:0]                             out_code,
  input logic                                   out_last,
  input logic                                   cfg_valid,
  input logic                                   cfg_ready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_code))
    else $error("stalled result changed");

  // an edge seen in reset leaves no result behind
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid)
    else $error("result shown during reset");

  // length and alignment errors always close the job
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_code == acf_pkg::ST_SHORT || out_code == acf_pkg::ST_MISALIGN)
    |-> out_last)
    else $error("error status without end of stream");

  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input taken right after a register write");

endmodule

bind audio_segment_crossfader_core acf_checker u_acf_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (sample_if.ready),
  .out_valid (result_if.valid),
  .out_ready (result_if.ready),
  .out_sample(result_if.sample_out),
  .out_code  (result_if.status_code),
  .out_last  (result_if.stream_last),
  .cfg_valid (cfg_if.valid),
  .cfg_ready (cfg_if.ready)
);
